// ===== hw/rtl/mlfq_pkg.sv =====
// mlfq_pkg: shared types and codes for the multilevel feedback queue scheduler
// used by mlfq_ctrl, mlfq_dp and mlfq_thread_scheduler; no dependencies
package mlfq_pkg;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_WAKE    = 3'd1;
    localparam logic [2:0] CMD_PREEMPT = 3'd2;
    localparam logic [2:0] CMD_BLOCK   = 3'd3;
    localparam logic [2:0] CMD_EXIT    = 3'd4;

    localparam logic [0:0] REG_QUANTUM = 1'b0;
    localparam logic [0:0] REG_BOOST   = 1'b1;

    localparam int unsigned TIME_W   = 21;
    localparam int unsigned QUANTA_W = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BOOST_POP,
        ST_BOOST_PUSH,
        ST_CUR_POP,
        ST_CUR_PUSH,
        ST_REMOVE,
        ST_FINISH,
        ST_RESULT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch_in;     // capture beat
        logic do_create;    // enqueue new or woken thread
        logic boost_pop;    // pop head of lowest nonzero level for boost
        logic boost_push;   // append popped thread at level 0
        logic cur_pop;      // pop running thread (preempt)
        logic cur_push;     // charge and append running thread
        logic remove;       // block or exit running thread
        logic clear_time;   // boost finished
        logic add_time;     // charge quantum to time counter
        logic set_result;   // load output register
        logic set_error;    // result error flag
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       id_bad;      // id queued or out of range
        logic       any_queued;
        logic       boost_due;
        logic       boost_left;  // some thread queued below level 0
    } dp_sts_t;

endpackage

// ===== hw/rtl/mlfq_dp.sv =====
// mlfq_dp: run queues, per-thread tables, time counter and result register
// depends on mlfq_pkg
module mlfq_dp #(
    parameter int LEVELS      = 4,
    parameter int MAX_THREADS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [2:0]           in_cmd,
    input  logic [5:0]           in_id,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [19:0]          cfg_data,
    input  mlfq_pkg::dp_cmd_t    ctl,
    output mlfq_pkg::dp_sts_t    sts,
    output logic [5:0]           res_id,
    output logic                 res_valid,
    output logic                 res_error
);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;

    logic [2:0]  cmd_reg;
    logic [5:0]  id_reg;
    logic [15:0] quantum_reg;
    logic [19:0] boost_reg;
    logic [mlfq_pkg::TIME_W-1:0] time_reg;

    logic [TW-1:0] head_reg [LEVELS];
    logic [TW-1:0] tail_reg [LEVELS];
    logic [LEVELS-1:0] nonempty_reg;
    logic [MAX_THREADS-1:0] inq_reg;
    logic [TW-1:0] link_mem [MAX_THREADS];
    logic [LW-1:0] level_mem [MAX_THREADS];
    logic [mlfq_pkg::QUANTA_W-1:0] quanta_mem [MAX_THREADS];

    logic [TW-1:0] pop_id_reg;     // thread held between pop and push
    logic [LW-1:0] pop_lvl_reg;

    // registered table reads
    logic [TW-1:0] link_rd_reg;    // next link of the last popped head
    logic [LW-1:0] level_rd_reg;   // kept level of the id in the accepted beat
    logic [mlfq_pkg::QUANTA_W-1:0] quanta_rd_reg;
    logic          fix_reg;        // head of pop_lvl_reg still to advance

    // queue heads with the pending advance forwarded
    logic [TW-1:0] head_cur [LEVELS];
    always_comb
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            head_cur[i] = (fix_reg && pop_lvl_reg == LW'(i)) ? link_rd_reg : head_reg[i];
        end
    end

    // lowest nonempty level
    logic [LW-1:0] top_lvl;
    logic [LW-1:0] low_lvl;        // lowest nonempty level above 0
    logic          low_any;
    always_comb
    begin
        top_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                top_lvl = LW'(i);
            end
        end
        low_lvl = '0;
        low_any = 1'b0;
        for (int i = LEVELS - 1; i >= 1; i--)
        begin
            if (nonempty_reg[i])
            begin
                low_lvl = LW'(i);
                low_any = 1'b1;
            end
        end
    end

    logic [TW-1:0] id_sel;
    logic          id_range;
    assign id_range = (32'(id_reg) < 32'(MAX_THREADS));
    assign id_sel   = TW'(id_reg);

    assign sts.cmd        = cmd_reg;
    assign sts.id_bad     = !id_range || inq_reg[id_sel];
    assign sts.any_queued = |nonempty_reg;
    assign sts.boost_due  = ({1'b0, boost_reg} <= time_reg);
    assign sts.boost_left = low_any;

    // push target for current op
    logic [TW-1:0] push_id;
    logic [LW-1:0] push_lvl;
    logic          push_en;
    logic [TW-1:0] pop_lvl_head;
    logic [LW-1:0] pop_lvl;
    logic          pop_en;
    logic [mlfq_pkg::QUANTA_W-1:0] q_cur, q_new;
    logic [LW-1:0] cur_lvl_new;

    assign q_cur = quanta_rd_reg;
    assign q_new = (q_cur == '1) ? q_cur : q_cur + 1'b1;
    always_comb
    begin
        cur_lvl_new = pop_lvl_reg;
        if ((32'(pop_lvl_reg) < LEVELS - 1) &&
            ({1'b0, q_new} >= 9'({pop_lvl_reg, 1'b0}) + 9'd2))
        begin
            cur_lvl_new = pop_lvl_reg + 1'b1;
        end
    end

    always_comb
    begin
        push_en  = 1'b0;
        push_id  = id_sel;
        push_lvl = '0;
        pop_en   = 1'b0;
        pop_lvl  = top_lvl;
        if (ctl.do_create)
        begin
            push_en  = 1'b1;
            push_lvl = (cmd_reg == mlfq_pkg::CMD_CREATE) ? '0 : level_rd_reg;
        end
        else if (ctl.boost_push)
        begin
            push_en = 1'b1;
            push_id = pop_id_reg;
        end
        else if (ctl.cur_push)
        begin
            push_en  = 1'b1;
            push_id  = pop_id_reg;
            push_lvl = cur_lvl_new;
        end
        if (ctl.boost_pop)
        begin
            pop_en  = 1'b1;
            pop_lvl = low_lvl;
        end
        else if (ctl.cur_pop || ctl.remove)
        begin
            pop_en = 1'b1;
        end
    end
    assign pop_lvl_head = head_cur[pop_lvl];

    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg      <= in_cmd;
            id_reg       <= in_id;
            level_rd_reg <= level_mem[TW'(in_id)];
        end
        if (pop_en)
        begin
            pop_id_reg    <= pop_lvl_head;
            pop_lvl_reg   <= pop_lvl;
            link_rd_reg   <= link_mem[pop_lvl_head];
            quanta_rd_reg <= quanta_mem[pop_lvl_head];
        end
        if (push_en && nonempty_reg[push_lvl])
        begin
            link_mem[tail_reg[push_lvl]] <= push_id;
        end
        if (ctl.do_create)
        begin
            if (cmd_reg == mlfq_pkg::CMD_CREATE)
            begin
                level_mem[id_sel]  <= '0;
                quanta_mem[id_sel] <= '0;
            end
        end
        if (ctl.boost_push)
        begin
            level_mem[pop_id_reg] <= '0;
        end
        if (ctl.cur_push)
        begin
            level_mem[pop_id_reg]  <= cur_lvl_new;
            quanta_mem[pop_id_reg] <= q_new;
        end
        if (ctl.remove && cmd_reg == mlfq_pkg::CMD_BLOCK && sts.boost_due)
        begin
            level_mem[pop_lvl_head] <= '0;
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            // head advances in the cycle after its pop, once the link is read
            if (fix_reg && pop_lvl_reg == LW'(i))
            begin
                head_reg[i] <= link_rd_reg;
            end
            if (push_en && push_lvl == LW'(i))
            begin
                tail_reg[i] <= push_id;
                if (!nonempty_reg[i] || (pop_en && pop_lvl == LW'(i) &&
                    head_cur[i] == tail_reg[i]))
                begin
                    head_reg[i] <= push_id;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= '0;
            inq_reg      <= '0;
            fix_reg      <= 1'b0;
            time_reg     <= '0;
            quantum_reg  <= 16'd10000;
            boost_reg    <= 20'd2000;
            res_id       <= '0;
            res_valid    <= 1'b0;
            res_error    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mlfq_pkg::REG_QUANTUM: quantum_reg <= cfg_data[15:0];
                    mlfq_pkg::REG_BOOST:   boost_reg   <= cfg_data;
                    default:               ;
                endcase
            end
            fix_reg <= pop_en && (pop_lvl_head != tail_reg[pop_lvl]);
            for (int i = 0; i < LEVELS; i++)
            begin
                if (pop_en && pop_lvl == LW'(i) && head_cur[i] == tail_reg[i])
                begin
                    nonempty_reg[i] <= 1'b0;
                end
                if (push_en && push_lvl == LW'(i))
                begin
                    nonempty_reg[i] <= 1'b1;
                end
            end
            if (pop_en)
            begin
                inq_reg[pop_lvl_head] <= 1'b0;
            end
            if (push_en)
            begin
                inq_reg[push_id] <= 1'b1;
            end
            if (ctl.clear_time)
            begin
                time_reg <= '0;
            end
            else if (ctl.add_time)
            begin
                time_reg <= (22'(time_reg) + 22'(quantum_reg) > 22'h1FFFFF) ?
                            '1 : time_reg + 21'(quantum_reg);
            end
            if (ctl.set_result)
            begin
                res_valid <= |nonempty_reg;
                res_id    <= (|nonempty_reg) ? 6'(head_cur[top_lvl]) : '0;
                res_error <= ctl.set_error;
            end
        end
    end
endmodule

// ===== hw/rtl/mlfq_ctrl.sv =====
// mlfq_ctrl: sequencing state machine for scheduler events
// depends on mlfq_pkg
module mlfq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  mlfq_pkg::dp_sts_t sts,
    output logic              in_ready,
    output logic              out_valid,
    output mlfq_pkg::dp_cmd_t ctl
);
    mlfq_pkg::state_t state_reg, state_next;
    logic err_reg, err_next;
    logic rm_reg, rm_next;   // block/exit path: boost after removal

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlfq_pkg::ST_IDLE;
            err_reg   <= 1'b0;
            rm_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
            rm_reg    <= rm_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        rm_next    = rm_reg;
        case (state_reg)
            mlfq_pkg::ST_IDLE:
                if (in_fire) state_next = mlfq_pkg::ST_DECODE;
            mlfq_pkg::ST_DECODE:
            begin
                err_next   = 1'b0;
                rm_next    = 1'b0;
                state_next = mlfq_pkg::ST_FINISH;
                case (sts.cmd)
                    mlfq_pkg::CMD_CREATE, mlfq_pkg::CMD_WAKE:
                        err_next = sts.id_bad;
                    mlfq_pkg::CMD_PREEMPT:
                        if (!sts.any_queued) err_next = 1'b1;
                        else if (sts.boost_due) state_next = mlfq_pkg::ST_BOOST_POP;
                        else state_next = mlfq_pkg::ST_CUR_POP;
                    mlfq_pkg::CMD_BLOCK, mlfq_pkg::CMD_EXIT:
                        if (!sts.any_queued) err_next = 1'b1;
                        else
                        begin
                            rm_next    = 1'b1;
                            state_next = mlfq_pkg::ST_REMOVE;
                        end
                    default: err_next = 1'b1;
                endcase
            end
            mlfq_pkg::ST_REMOVE:
                state_next = sts.boost_due ? mlfq_pkg::ST_BOOST_POP : mlfq_pkg::ST_FINISH;
            mlfq_pkg::ST_BOOST_POP:
                state_next = sts.boost_left ? mlfq_pkg::ST_BOOST_PUSH :
                             (rm_reg ? mlfq_pkg::ST_FINISH : mlfq_pkg::ST_CUR_POP);
            mlfq_pkg::ST_BOOST_PUSH:
                state_next = mlfq_pkg::ST_BOOST_POP;
            mlfq_pkg::ST_CUR_POP:
                state_next = mlfq_pkg::ST_CUR_PUSH;
            mlfq_pkg::ST_CUR_PUSH:
                state_next = mlfq_pkg::ST_FINISH;
            mlfq_pkg::ST_FINISH:
                state_next = mlfq_pkg::ST_RESULT;
            mlfq_pkg::ST_RESULT:
                if (out_fire) state_next = mlfq_pkg::ST_IDLE;
            default:
                state_next = mlfq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            mlfq_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctl.latch_in = 1'b1;
            end
            mlfq_pkg::ST_DECODE:
                ctl.do_create = (sts.cmd == mlfq_pkg::CMD_CREATE ||
                                 sts.cmd == mlfq_pkg::CMD_WAKE) && !sts.id_bad;
            mlfq_pkg::ST_REMOVE:
                ctl.remove = 1'b1;
            mlfq_pkg::ST_BOOST_POP:
            begin
                ctl.boost_pop  = sts.boost_left;
                ctl.clear_time = !sts.boost_left;
            end
            mlfq_pkg::ST_BOOST_PUSH:
                ctl.boost_push = 1'b1;
            mlfq_pkg::ST_CUR_POP:
                ctl.cur_pop = 1'b1;
            mlfq_pkg::ST_CUR_PUSH:
                ctl.cur_push = 1'b1;
            mlfq_pkg::ST_FINISH:
            begin
                ctl.add_time   = !err_reg && (sts.cmd == mlfq_pkg::CMD_PREEMPT ||
                                  sts.cmd == mlfq_pkg::CMD_BLOCK ||
                                  sts.cmd == mlfq_pkg::CMD_EXIT);
                ctl.set_result = 1'b1;
                ctl.set_error  = err_reg;
            end
            mlfq_pkg::ST_RESULT:
                out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== hw/rtl/mlfq_thread_scheduler.sv =====
// mlfq_thread_scheduler: multilevel feedback queue scheduler, top level
// sequence: each command beat passes the decode, finish and result states; a valid
//   preempt adds a pop and a push of the running thread, block and exit add a removal,
//   and a boost adds one pop and one push per thread moved up to level 0 plus a closing state
// throughput: one event at a time, next beat taken the cycle after the result beat leaves
// reset: asynchronous, all queues empty, quantum 10000, boost period 2000
module mlfq_thread_scheduler #(
    parameter int LEVELS      = 4,
    parameter int MAX_THREADS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // cmd[2:0], thread_id[8:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // running_id[5:0], running_valid[6], error[7]
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    mlfq_pkg::dp_cmd_t ctl;
    mlfq_pkg::dp_sts_t sts;
    logic [5:0] res_id;
    logic       res_valid;
    logic       res_error;

    // controller sequences pops and pushes of the shared queue port
    mlfq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .out_fire (m_axis_tvalid && m_axis_tready),
        .sts      (sts),
        .in_ready (s_axis_tready),
        .out_valid(m_axis_tvalid),
        .ctl      (ctl)
    );

    // datapath holds queues, tables and the result register
    mlfq_dp #(
        .LEVELS     (LEVELS),
        .MAX_THREADS(MAX_THREADS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_cmd   (s_axis_tdata[2:0]),
        .in_id    (s_axis_tdata[8:3]),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .ctl      (ctl),
        .sts      (sts),
        .res_id   (res_id),
        .res_valid(res_valid),
        .res_error(res_error)
    );

    assign m_axis_tdata = {res_error, res_valid, res_id};
endmodule

// ===== tb/mlfq_sched_checker.sv =====
// mlfq_sched_checker: watches the command and result streams of the mlfq scheduler,
// predicts each result beat and compares it; depends on mlfq_pkg
`timescale 1ns / 1ps

module mlfq_sched_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          fail_count,
    output int          pending_results
);
    localparam int NLVL = 4;
    localparam int NTHR = 64;
    localparam logic [20:0] TIME_SAT = 21'h1FFFFF;

    typedef struct packed {
        logic       error;
        logic       running_valid;
        logic [5:0] running_id;
    } sched_result_t;

    logic [15:0] slice_us;
    logic [19:0] boost_us;
    logic [5:0]  lvl_head [NLVL];
    logic [5:0]  lvl_tail [NLVL];
    logic        lvl_busy [NLVL];
    logic [5:0]  link     [NTHR];
    logic [1:0]  thr_lvl  [NTHR];
    logic [7:0]  thr_quanta [NTHR];
    logic        queued   [NTHR];
    logic [20:0] run_time;
    sched_result_t expected_results[$];

    function automatic int first_level();
        for (int l = 0; l < NLVL; l++)
            if (lvl_busy[l])
                return l;
        return NLVL;
    endfunction

    task automatic enqueue(input int l, input logic [5:0] id);
        if (lvl_busy[l])
            link[lvl_tail[l]] = id;
        else
            lvl_head[l] = id;
        lvl_tail[l] = id;
        lvl_busy[l] = 1'b1;
        queued[id] = 1'b1;
    endtask

    task automatic dequeue(input int l, output logic [5:0] id);
        id = lvl_head[l];
        if (lvl_head[l] == lvl_tail[l])
            lvl_busy[l] = 1'b0;
        else
            lvl_head[l] = link[id];
        queued[id] = 1'b0;
    endtask

    task automatic boost_check();
        logic [5:0] id;
        if (run_time < {1'b0, boost_us})
            return;
        run_time = '0;
        for (int l = 1; l < NLVL; l++)
            while (lvl_busy[l])
            begin
                dequeue(l, id);
                thr_lvl[id] = 2'd0;
                enqueue(0, id);
            end
    endtask

    task automatic charge_time();
        logic [21:0] t;
        t = run_time + slice_us;
        run_time = (t > TIME_SAT) ? TIME_SAT : t[20:0];
    endtask

    // one scheduling event in, one result out
    task automatic schedule_event(input logic [2:0] cmd, input logic [5:0] id);
        sched_result_t r;
        logic          err;
        logic [5:0]    cur;
        int            top;
        int            l;
        err = 1'b0;
        top = first_level();
        if (cmd == mlfq_pkg::CMD_CREATE || cmd == mlfq_pkg::CMD_WAKE)
        begin
            if (queued[id])
                err = 1'b1;
            else
            begin
                if (cmd == mlfq_pkg::CMD_CREATE)
                begin
                    thr_lvl[id] = 2'd0;
                    thr_quanta[id] = 8'd0;
                end
                enqueue(thr_lvl[id], id);
            end
        end
        else if (cmd == mlfq_pkg::CMD_PREEMPT)
        begin
            if (top >= NLVL)
                err = 1'b1;
            else
            begin
                boost_check();
                l = first_level();
                dequeue(l, cur);
                if (thr_quanta[cur] != 8'hFF)
                    thr_quanta[cur]++;
                if (l < NLVL - 1 && thr_quanta[cur] >= 2 * (l + 1))
                    l++;
                thr_lvl[cur] = l[1:0];
                enqueue(l, cur);
                charge_time();
            end
        end
        else if (cmd == mlfq_pkg::CMD_BLOCK || cmd == mlfq_pkg::CMD_EXIT)
        begin
            if (top >= NLVL)
                err = 1'b1;
            else
            begin
                dequeue(top, cur);
                if (cmd == mlfq_pkg::CMD_BLOCK && run_time >= {1'b0, boost_us})
                    thr_lvl[cur] = 2'd0;
                boost_check();
                charge_time();
            end
        end
        else
            err = 1'b1;
        top = first_level();
        r.running_id = (top < NLVL) ? lvl_head[top] : 6'd0;
        r.running_valid = (top < NLVL);
        r.error = err;
        expected_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got;
        sched_result_t exp_r;
        if (!rst_n)
        begin
            slice_us = 16'd10000;
            boost_us = 20'd2000;
            run_time = '0;
            for (int l = 0; l < NLVL; l++)
            begin
                lvl_head[l] = '0;
                lvl_tail[l] = '0;
                lvl_busy[l] = 1'b0;
            end
            for (int i = 0; i < NTHR; i++)
            begin
                link[i] = '0;
                thr_lvl[i] = '0;
                thr_quanta[i] = '0;
                queued[i] = 1'b0;
            end
            expected_results.delete();
            fail_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == mlfq_pkg::REG_QUANTUM)
                    slice_us = cfg_data[15:0];
                else
                    boost_us = cfg_data;
            end
            // result beat checked before the new command so ordering is kept
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got.running_id !== exp_r.running_id)
                    begin
                        $error("running_id expected %0d actual %0d",
                               exp_r.running_id, got.running_id);
                        fail_count++;
                    end
                    if (got.running_valid !== exp_r.running_valid)
                    begin
                        $error("running_valid expected %0b actual %0b",
                               exp_r.running_valid, got.running_valid);
                        fail_count++;
                    end
                    if (got.error !== exp_r.error)
                    begin
                        $error("error expected %0b actual %0b", exp_r.error, got.error);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                schedule_event(s_axis_tdata[2:0], s_axis_tdata[8:3]);
            pending_results = expected_results.size();
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: stimulus and verdict for mlfq_thread_scheduler
// depends on mlfq_pkg, mlfq_sched_checker and the scheduler rtl
`timescale 1ns / 1ps

module tb_top;
    // command codes outside the defined set
    localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // cmd[2:0], thread_id[8:3]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // running_id[5:0], running_valid[6], error[7]
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [19:0] cfg_data;
    int          fail_count;
    int          pending_results;

    // receiver idling percentage and long hold-off request
    int          sink_idle_pct;
    logic        sink_hold;
    // ids that were created at least once, so a wake never reads unwritten state
    logic        ever_created [64];

    mlfq_thread_scheduler DUT (.*);

    mlfq_sched_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard timeout: slowest legal run is far below this
    initial
    begin
        #100ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver side: random stalls, plus one long hold-off when asked
    initial
    begin
        logic hold_done;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // push one command beat; sender may idle before offering it
    task automatic send_cmd(input logic [2:0] cmd, input logic [5:0] id, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {7'h00, id, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == mlfq_pkg::CMD_CREATE)
            ever_created[id] = 1'b1;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [19:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly legal traffic: create new ids, wake created ones, and run the queue
    task automatic random_cmds(input int count, input int idle_pct);
        int          pick;
        logic [5:0]  id;
        logic [2:0]  cmd;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            id = 6'($urandom_range(63));
            if (pick < 25)
                cmd = mlfq_pkg::CMD_CREATE;
            else if (pick < 40)
                cmd = mlfq_pkg::CMD_WAKE;
            else if (pick < 75)
                cmd = mlfq_pkg::CMD_PREEMPT;
            else if (pick < 85)
                cmd = mlfq_pkg::CMD_BLOCK;
            else if (pick < 95)
                cmd = mlfq_pkg::CMD_EXIT;
            else
                cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
            // never wake an id whose level was never written
            if (cmd == mlfq_pkg::CMD_WAKE && !ever_created[id])
                cmd = mlfq_pkg::CMD_CREATE;
            send_cmd(cmd, id, idle_pct);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = mlfq_pkg::REG_QUANTUM;
        cfg_data = '0;
        sink_idle_pct = 48;
        sink_hold = 1'b0;
        for (int i = 0; i < 64; i++)
            ever_created[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle errors, bad commands, extremes of id, duplicates, full drain
        send_cmd(mlfq_pkg::CMD_PREEMPT, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_BLOCK, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_EXIT, 6'd0, 0);
        send_cmd(CMD_RSVD_LO, 6'd63, 0);
        send_cmd(CMD_RSVD_HI, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_CREATE, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_CREATE, 6'd63, 0);
        send_cmd(mlfq_pkg::CMD_CREATE, 6'd63, 0);   // already queued
        send_cmd(mlfq_pkg::CMD_WAKE, 6'd0, 0);      // already queued
        send_cmd(mlfq_pkg::CMD_PREEMPT, 6'd0, 0);   // no boost due yet at reset settings; this charge makes one due
        send_cmd(mlfq_pkg::CMD_PREEMPT, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_BLOCK, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_WAKE, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_EXIT, 6'd0, 0);
        send_cmd(mlfq_pkg::CMD_EXIT, 6'd0, 0);
        send_cmd(CMD_RSVD_MID, 6'd21, 0);
        s_axis_tvalid <= 1'b0;

        // long boost period so threads sink through the levels
        write_reg(mlfq_pkg::REG_BOOST, 20'hFFFFF);
        write_reg(mlfq_pkg::REG_QUANTUM, 16'd1);
        for (int i = 0; i < 6; i++)
            send_cmd(mlfq_pkg::CMD_CREATE, 6'(i * 12), 0);
        for (int i = 0; i < 60; i++)
            send_cmd(mlfq_pkg::CMD_PREEMPT, 6'd0, 0);
        s_axis_tvalid <= 1'b0;

        random_cmds(450, 37);                    // sender 37, receiver 48
        write_reg(mlfq_pkg::REG_QUANTUM, 16'hFFFF);
        write_reg(mlfq_pkg::REG_BOOST, 20'd0);
        sink_idle_pct = 37;
        random_cmds(300, 48);                    // sender 48, receiver 37
        write_reg(mlfq_pkg::REG_QUANTUM, 16'd100);
        write_reg(mlfq_pkg::REG_BOOST, 20'd1500);
        sink_idle_pct = 0;
        sink_hold = 1'b1;                        // long stall while sender keeps offering
        random_cmds(500, 0);
        write_reg(mlfq_pkg::REG_QUANTUM, 16'd7);
        write_reg(mlfq_pkg::REG_BOOST, 20'd300);
        random_cmds(500, 0);

        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== mlfq_thread_scheduler.f =====
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_dp.sv
hw/rtl/mlfq_ctrl.sv
hw/rtl/mlfq_thread_scheduler.sv
tb/mlfq_sched_checker.sv
tb/tb_top.sv
